FILE: rtl/core/erd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_pkg: shared types, sizes and arithmetic for the early reflection block
// Sample and coefficient formats, store sizes, register indexes, and the
// round and saturate helpers used around the shared multiplier.
// ----------------------------------------------------------------------------
package erd_pkg;

  // Field widths and fixed-point formats (Q1.23 samples, Q1.15 gains)
  localparam int SMP_W     = 24;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;
  localparam int DLY_W     = 9;
  localparam int TAP_DLY_W = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Store sizes; both depths are powers of two so positions wrap for free
  localparam int TAP_COUNT  = 16;
  localparam int LINE_DEPTH = 16384;
  localparam int DIF_DEPTH  = 512;
  localparam int DIF_TOT    = 4 * DIF_DEPTH;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int DIF_AW     = $clog2(DIF_DEPTH);
  localparam int DIF_TOT_AW = DIF_AW + 2;
  localparam int TAP_AW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CLR_DEPTH  = (LINE_DEPTH > DIF_TOT) ? LINE_DEPTH : DIF_TOT;
  localparam int CLR_AW     = $clog2(CLR_DEPTH);

  // Datapath widths
  localparam int PROD_W = SMP_W + COEF_W;
  localparam int RND_W  = PROD_W + 1 - COEF_FRAC;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;
  localparam int SAT_W  = 48;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(8388607);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(8388608);
  localparam int RND_HALF = 1 << (COEF_FRAC - 1);

  // Input item kinds
  localparam logic MODE_AUDIO = 1'b0;
  localparam logic MODE_TAP   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DLY_LA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DLY_LB = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DLY_RA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DLY_RB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd5;

  // Register reset values
  localparam logic [DLY_W-1:0]  RST_DLY_LA = 9'd75;
  localparam logic [DLY_W-1:0]  RST_DLY_LB = 9'd137;
  localparam logic [DLY_W-1:0]  RST_DLY_RA = 9'd93;
  localparam logic [DLY_W-1:0]  RST_DLY_RB = 9'd163;
  localparam logic [COEF_W-1:0] RST_COEFF  = 16'd16384;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Memory port commands from the sequencer
  typedef struct packed {
    logic                  dif_we;
    logic [DIF_TOT_AW-1:0] dif_waddr;
    smp_t                  dif_wdata;
    logic [DIF_TOT_AW-1:0] dif_raddr;
    logic                  line_we_l;
    logic                  line_we_r;
    logic [LINE_AW-1:0]    line_waddr;
    smp_t                  line_wdata;
    logic [LINE_AW-1:0]    line_raddr;
  } mem_cmd_t;

  // Accumulator control for the shared multiplier
  typedef struct packed {
    logic acc_clr;
    logic acc_en;
  } mac_cmd_t;

  // Round a Q1.23 x Q1.15 product back to Q1.23, half up
  function automatic logic signed [RND_W-1:0] rnd15(input prod_t p);
    logic signed [PROD_W:0] t;
    t = {p[PROD_W-1], p} + (PROD_W+1)'(RND_HALF);
    return t[PROD_W:COEF_FRAC];
  endfunction

  // Clamp to the Q1.23 range
  function automatic smp_t sat_smp(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] y;
    y = x;
    if (x > SAT_HI) y = SAT_HI;
    if (x < SAT_LO) y = SAT_LO;
    return y[SMP_W-1:0];
  endfunction

endpackage

FILE: rtl/core/erd_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_mac: shared multiplier with accumulator
// Multiplies one sample by one Q1.15 value each cycle into a product
// register, and optionally adds the product into the tap accumulator.
// ----------------------------------------------------------------------------
module erd_mac (
  input  logic              clk,
  input  logic              rst,
  input  erd_pkg::mac_cmd_t cmd,
  input  erd_pkg::smp_t     op_a,
  input  erd_pkg::coef_t    op_b,
  output erd_pkg::prod_t    prod,
  output erd_pkg::acc_t     acc
);
  import erd_pkg::*;

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Clear or accumulate the registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

FILE: rtl/core/erd_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_mem: diffuser store and the two reflection lines
// One write and one registered read per store each cycle. The reflection
// lines share a read address; both read data words are registered.
// ----------------------------------------------------------------------------
module erd_mem (
  input  logic              clk,
  input  erd_pkg::mem_cmd_t cmd,
  output erd_pkg::smp_t     dif_rdata,
  output erd_pkg::smp_t     line_rdata_l,
  output erd_pkg::smp_t     line_rdata_r
);
  import erd_pkg::*;

  smp_t dif_store [DIF_TOT];
  smp_t line_l    [LINE_DEPTH];
  smp_t line_r    [LINE_DEPTH];

  // Diffuser store: four regions, one per allpass
  always_ff @(posedge clk) begin
    if (cmd.dif_we) begin
      dif_store[cmd.dif_waddr] <= cmd.dif_wdata;
    end
    dif_rdata <= dif_store[cmd.dif_raddr];
  end

  // Left reflection line
  always_ff @(posedge clk) begin
    if (cmd.line_we_l) begin
      line_l[cmd.line_waddr] <= cmd.line_wdata;
    end
    line_rdata_l <= line_l[cmd.line_raddr];
  end

  // Right reflection line
  always_ff @(posedge clk) begin
    if (cmd.line_we_r) begin
      line_r[cmd.line_waddr] <= cmd.line_wdata;
    end
    line_rdata_r <= line_r[cmd.line_raddr];
  end

endmodule

FILE: rtl/core/early_reflection_tapped_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// early_reflection_tapped_delay: stereo allpass-diffused multitap reflections
// Sequencer around one shared multiplier, the delay stores and tap tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 carries a stereo sample pair,
//   mode 1 writes one tap delay and gain entry. A transfer happens on a clock
//   edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one result pair per sample pair,
//   none per tap write. Results sit in an output register until taken.
//   Config port (cfg_we / cfg_index / cfg_data): write only while idle.
// Sequence:
//   A sample pair runs the left diffusers, then (in stereo) the right ones,
//   then the tap sums; no new item is taken until its result is loaded into
//   the output register. Each diffuser (four in stereo, two in mono) steps
//   through read, multiply and write states; the tap sums take one tap per
//   multiplier cycle plus a drain per channel. A tap write leaves the block idle.
// Reset:
//   rst is synchronous. After reset the block clears every entry of the delay
//   stores with in_stall high; config writes are still taken.
// Stall:
//   If a new result is ready while the last one is still stalled, the block
//   holds it, with in_stall high, until the output register frees up.
// ----------------------------------------------------------------------------
module early_reflection_tapped_delay (
  input  logic                                 clk,
  input  logic                                 rst,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic signed [erd_pkg::SMP_W-1:0]     sample_left,
  input  logic signed [erd_pkg::SMP_W-1:0]     sample_right,
  input  logic                                 tap_channel,
  input  logic [3:0]                           tap_index,
  input  logic [erd_pkg::TAP_DLY_W-1:0]        tap_delay,
  input  logic signed [erd_pkg::COEF_W-1:0]    tap_gain,
  // results
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [erd_pkg::SMP_W-1:0]     out_left,
  output logic signed [erd_pkg::SMP_W-1:0]     out_right,
  // configuration
  input  logic                                 cfg_we,
  input  logic [erd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [erd_pkg::CFG_W-1:0]            cfg_data
);
  import erd_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DIF_RD  = 3'd2;
  localparam logic [2:0] S_DIF_MUL = 3'd3;
  localparam logic [2:0] S_DIF_WR  = 3'd4;
  localparam logic [2:0] S_LINE_WR = 3'd5;
  localparam logic [2:0] S_TAP     = 3'd6;
  localparam logic [2:0] S_DRAIN   = 3'd7;

  localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);
  localparam logic [CLR_AW:0]   LINE_END = (CLR_AW+1)'(LINE_DEPTH);
  localparam logic [CLR_AW:0]   DIF_END  = (CLR_AW+1)'(DIF_TOT);
  localparam logic [TAP_AW-1:0] TAP_LAST = TAP_AW'(TAP_COUNT - 1);

  // Configuration registers
  logic [DLY_W-1:0] cfg_dly [4];
  coef_t            diffuser_coeff;
  logic             stereo_enable;

  // Tap tables
  logic [TAP_DLY_W-1:0] tap_dly_tab  [2][TAP_COUNT];
  coef_t                tap_gain_tab [2][TAP_COUNT];

  // Sequencer state
  logic [2:0]        state, state_next;
  logic [CLR_AW-1:0] clr_cnt;
  logic [DIF_AW-1:0] wpos;
  logic [LINE_AW-1:0] lpos;
  logic [1:0]        dif_k;
  logic              ch;
  logic [TAP_AW-1:0] tap_t;
  logic              tap_v1, tap_v2;

  // Datapath registers
  smp_t  cur, dout, dry_l, dry_r, res_l;
  coef_t gain_q;

  // Shared unit and memory connections
  mem_cmd_t mem_cmd;
  mac_cmd_t mac_cmd;
  smp_t     op_a;
  coef_t    op_b;
  prod_t    prod;
  acc_t     acc;
  smp_t     dif_rdata, line_rdata_l, line_rdata_r;

  // Combinational helpers
  logic                     in_xfer, out_load, load_ok, drain_done;
  logic [DLY_W-1:0]         dif_dly;
  logic [DIF_AW-1:0]        dif_rpos;
  logic signed [RND_W-1:0]  prod_rnd;
  logic signed [ACC_W:0]    acc_rnd_full;
  logic signed [ACC_W-COEF_FRAC:0] acc_rnd;
  smp_t                     dif_out_val, dif_store_val, dry_sel, tap_res;

  erd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  erd_mem u_mem (
    .clk          (clk),
    .cmd          (mem_cmd),
    .dif_rdata    (dif_rdata),
    .line_rdata_l (line_rdata_l),
    .line_rdata_r (line_rdata_r)
  );

  assign in_stall   = (state != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign load_ok    = !out_valid || !out_stall;
  assign drain_done = (state == S_DRAIN) && !tap_v1 && !tap_v2;
  assign out_load   = drain_done && (ch || !stereo_enable) && load_ok;

  // Arithmetic around the product and accumulator
  assign dif_dly       = cfg_dly[dif_k];
  assign dif_rpos      = wpos - DIF_AW'(dif_dly);
  assign prod_rnd      = rnd15(prod);
  assign dif_out_val   = sat_smp(SAT_W'(dif_rdata) - SAT_W'(prod_rnd));
  assign dif_store_val = sat_smp(SAT_W'(cur) + SAT_W'(prod_rnd));
  assign acc_rnd_full  = {acc[ACC_W-1], acc} + (ACC_W+1)'(RND_HALF);
  assign acc_rnd       = acc_rnd_full[ACC_W:COEF_FRAC];
  assign dry_sel       = ch ? dry_r : dry_l;
  assign tap_res       = sat_smp(SAT_W'(dry_sel) + SAT_W'(acc_rnd));

  // Next state, memory and multiplier controls
  always_comb begin
    state_next      = state;
    mem_cmd         = '0;
    mac_cmd.acc_clr = 1'b0;
    mac_cmd.acc_en  = tap_v2;
    op_a            = ch ? line_rdata_r : line_rdata_l;
    op_b            = gain_q;
    mem_cmd.line_raddr = lpos - LINE_AW'(tap_dly_tab[ch][tap_t]);
    unique case (state)
      S_CLEAR: begin
        mem_cmd.line_we_l  = ({1'b0, clr_cnt} < LINE_END);
        mem_cmd.line_we_r  = ({1'b0, clr_cnt} < LINE_END);
        mem_cmd.line_waddr = clr_cnt[LINE_AW-1:0];
        mem_cmd.dif_we     = ({1'b0, clr_cnt} < DIF_END);
        mem_cmd.dif_waddr  = clr_cnt[DIF_TOT_AW-1:0];
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && mode == MODE_AUDIO) begin
          state_next = S_DIF_RD;
        end
      end
      S_DIF_RD: begin
        mem_cmd.dif_raddr = {dif_k, dif_rpos};
        op_a       = cur;
        op_b       = diffuser_coeff;
        state_next = S_DIF_MUL;
      end
      S_DIF_MUL: begin
        op_a       = dif_rdata;
        op_b       = diffuser_coeff;
        state_next = S_DIF_WR;
      end
      S_DIF_WR: begin
        mem_cmd.dif_we    = 1'b1;
        mem_cmd.dif_waddr = {dif_k, wpos};
        mem_cmd.dif_wdata = dif_store_val;
        state_next = dif_k[0] ? S_LINE_WR : S_DIF_RD;
      end
      S_LINE_WR: begin
        mem_cmd.line_we_l  = !dif_k[1];
        mem_cmd.line_we_r  = dif_k[1];
        mem_cmd.line_waddr = lpos;
        mem_cmd.line_wdata = cur;
        if (!dif_k[1] && stereo_enable) begin
          state_next = S_DIF_RD;
        end else begin
          mac_cmd.acc_clr = 1'b1;
          state_next      = S_TAP;
        end
      end
      S_TAP: begin
        if (tap_t == TAP_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          if (!ch && stereo_enable) begin
            mac_cmd.acc_clr = 1'b1;
            state_next      = S_TAP;
          end else if (load_ok) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      wpos      <= '0;
      lpos      <= '0;
      dif_k     <= '0;
      ch        <= 1'b0;
      tap_t     <= '0;
      tap_v1    <= 1'b0;
      tap_v2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      tap_v1 <= (state == S_TAP);
      tap_v2 <= tap_v1;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_IDLE) begin
        dif_k <= '0;
      end
      // step to the next diffuser only when another one follows
      if ((state == S_DIF_WR || state == S_LINE_WR) && state_next == S_DIF_RD) begin
        dif_k <= dif_k + 1'b1;
      end
      // advance the shared write positions once the last line in use is written
      if (state == S_LINE_WR && state_next == S_TAP) begin
        wpos  <= wpos + 1'b1;
        lpos  <= lpos + 1'b1;
        ch    <= 1'b0;
        tap_t <= '0;
      end
      if (state == S_TAP) begin
        tap_t <= tap_t + 1'b1;
      end
      if (state == S_DRAIN && state_next == S_TAP) begin
        ch    <= 1'b1;
        tap_t <= '0;
      end
      // hold the result until the receiver takes it
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer && mode == MODE_AUDIO) begin
      cur   <= sample_left;
      dry_l <= sample_left;
      dry_r <= sample_right;
    end
    if (state == S_DIF_MUL) begin
      dout <= dif_out_val;
    end
    if (state == S_DIF_WR) begin
      cur <= dout;
    end
    if (state == S_LINE_WR && state_next == S_DIF_RD) begin
      cur <= dry_r;
    end
    if (state == S_TAP) begin
      gain_q <= tap_gain_tab[ch][tap_t];
    end
    if (drain_done && !ch) begin
      res_l <= tap_res;
    end
    if (out_load) begin
      out_left  <= ch ? res_l : tap_res;
      out_right <= ch ? tap_res : '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dly[0]     <= RST_DLY_LA;
      cfg_dly[1]     <= RST_DLY_LB;
      cfg_dly[2]     <= RST_DLY_RA;
      cfg_dly[3]     <= RST_DLY_RB;
      diffuser_coeff <= RST_COEFF;
      stereo_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DLY_LA: cfg_dly[0]     <= cfg_data[DLY_W-1:0];
        REG_DLY_LB: cfg_dly[1]     <= cfg_data[DLY_W-1:0];
        REG_DLY_RA: cfg_dly[2]     <= cfg_data[DLY_W-1:0];
        REG_DLY_RB: cfg_dly[3]     <= cfg_data[DLY_W-1:0];
        REG_COEFF:  diffuser_coeff <= cfg_data[COEF_W-1:0];
        REG_STEREO: stereo_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Tap table writes from mode 1 transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        for (int t = 0; t < TAP_COUNT; t++) begin
          tap_dly_tab[c][t]  <= TAP_DLY_W'(1);
          tap_gain_tab[c][t] <= '0;
        end
      end
    end else if (in_xfer && mode == MODE_TAP && (32'(tap_index) < 32'(TAP_COUNT))) begin
      tap_dly_tab[tap_channel][TAP_AW'(tap_index)]  <= tap_delay;
      tap_gain_tab[tap_channel][TAP_AW'(tap_index)] <= tap_gain;
    end
  end

  // Checks
  a_out_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DRAIN)
    else $error("result raised outside the tap drain");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result present during store clearing");

  a_pos_together: assert property (@(posedge clk) disable iff (rst)
    lpos != $past(lpos) |-> wpos != $past(wpos))
    else $error("line and diffuser positions out of step");

  a_tap_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_CLEAR) |-> !tap_v1 && !tap_v2)
    else $error("tap pipeline busy while idle");

  a_line_after_b: assert property (@(posedge clk) disable iff (rst)
    state == S_LINE_WR |-> dif_k[0] && $past(state) == S_DIF_WR)
    else $error("line written before second diffuser");

endmodule

FILE: tb/early_reflection_tapped_delay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// early_reflection_tapped_delay_tb: self-checking bench for the reflection block
// Drives sample pairs and tap table writes through the valid/stall channel and
// mirrors the diffusers, reflection lines and tap sums in a local predictor.
// Each result pair is compared against the oldest predicted pair. The bench
// covers register extremes, mono/stereo, saturation and a long output hold.
// ----------------------------------------------------------------------------
module early_reflection_tapped_delay_tb;
  import erd_pkg::*;

  localparam int     CYCLE_LIMIT   = 1500000;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     HOLD_CYCLES   = 700;
  localparam longint Q23_MAX       = 8388607;
  localparam longint Q23_MIN       = -8388608;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BLOCKS} flow_style_t;

  typedef struct {
    logic                 mode;
    smp_t                 dry_l;
    smp_t                 dry_r;
    logic                 chan;
    logic [3:0]           slot;
    logic [TAP_DLY_W-1:0] dly;
    coef_t                gain;
  } refl_item_t;

  typedef struct {
    smp_t out_l;
    smp_t out_r;
  } refl_pair_t;

  // DUT ports
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 mode         = MODE_AUDIO;
  smp_t                 sample_left  = '0;
  smp_t                 sample_right = '0;
  logic                 tap_channel  = 1'b0;
  logic [3:0]           tap_index    = '0;
  logic [TAP_DLY_W-1:0] tap_delay    = '0;
  coef_t                tap_gain     = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  smp_t                 out_left;
  smp_t                 out_right;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  // Predictor state
  smp_t                 line_l [LINE_DEPTH];
  smp_t                 line_r [LINE_DEPTH];
  smp_t                 dif_mem [DIF_TOT];
  int                   line_wpos;
  int                   dif_wpos;
  logic [TAP_DLY_W-1:0] tap_dly_tab [2][TAP_COUNT];
  coef_t                tap_gain_tab [2][TAP_COUNT];
  logic [DLY_W-1:0]     dif_dly [4];
  coef_t                coeff_q;
  logic                 stereo_on;

  // Bench bookkeeping
  refl_pair_t  expected_pairs [$];
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          burst_left   = 0;
  bit          no_gaps      = 1'b0;
  bit          hold_request = 1'b0;
  int          hold_left    = 0;
  int          style_left   = 0;
  flow_style_t stall_style  = FLOW_FREE;

  early_reflection_tapped_delay dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .tap_channel  (tap_channel),
    .tap_index    (tap_index),
    .tap_delay    (tap_delay),
    .tap_gain     (tap_gain),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_left     (out_left),
    .out_right    (out_right),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bring a Q1.23 x Q1.15 product back to Q1.23, round half up
  function automatic longint round_q15(longint x);
    return (x + 16384) >>> 15;
  endfunction

  function automatic smp_t clamp_q23(longint x);
    if (x > Q23_MAX) return smp_t'(Q23_MAX);
    if (x < Q23_MIN) return smp_t'(Q23_MIN);
    return smp_t'(x);
  endfunction

  // One Schroeder allpass: read the delayed entry, then overwrite the current one
  function automatic smp_t allpass_stage(int k, logic [DLY_W-1:0] dly, smp_t x);
    int     rp;
    longint held;
    rp   = (dif_wpos + DIF_DEPTH - (int'(dly) % DIF_DEPTH)) % DIF_DEPTH;
    held = longint'(dif_mem[k * DIF_DEPTH + rp]);
    dif_mem[k * DIF_DEPTH + dif_wpos] = clamp_q23(longint'(x) + round_q15(coeff_q * held));
    return clamp_q23(held - round_q15(coeff_q * longint'(x)));
  endfunction

  function automatic longint tap_total(bit ch);
    longint acc;
    int     rp;
    smp_t   s;
    acc = 0;
    for (int t = 0; t < TAP_COUNT; t++) begin
      rp  = (line_wpos + LINE_DEPTH - (int'(tap_dly_tab[ch][t]) % LINE_DEPTH)) % LINE_DEPTH;
      s   = ch ? line_r[rp] : line_l[rp];
      acc += longint'(s) * longint'(tap_gain_tab[ch][t]);
    end
    return round_q15(acc);
  endfunction

  // Diffuse, write the lines, advance, then sum the taps
  function automatic refl_pair_t predict_reflections(smp_t dl, smp_t dr);
    refl_pair_t res;
    smp_t       v;
    v = allpass_stage(0, dif_dly[0], dl);
    v = allpass_stage(1, dif_dly[1], v);
    line_l[line_wpos] = v;
    if (stereo_on) begin
      v = allpass_stage(2, dif_dly[2], dr);
      v = allpass_stage(3, dif_dly[3], v);
      line_r[line_wpos] = v;
    end
    dif_wpos  = (dif_wpos + 1) % DIF_DEPTH;
    line_wpos = (line_wpos + 1) % LINE_DEPTH;
    res.out_l = clamp_q23(longint'(dl) + tap_total(1'b0));
    res.out_r = stereo_on ? clamp_q23(longint'(dr) + tap_total(1'b1)) : '0;
    return res;
  endfunction

  task automatic reset_predictor();
    foreach (line_l[i]) line_l[i] = '0;
    foreach (line_r[i]) line_r[i] = '0;
    foreach (dif_mem[i]) dif_mem[i] = '0;
    foreach (tap_dly_tab[c, t]) begin
      tap_dly_tab[c][t]  = TAP_DLY_W'(1);
      tap_gain_tab[c][t] = '0;
    end
    line_wpos  = 0;
    dif_wpos   = 0;
    dif_dly[0] = RST_DLY_LA;
    dif_dly[1] = RST_DLY_LB;
    dif_dly[2] = RST_DLY_RA;
    dif_dly[3] = RST_DLY_RB;
    coeff_q    = coef_t'(RST_COEFF);
    stereo_on  = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Item builders and random picks
  // ---------------------------------------------------------------------------

  function automatic refl_item_t audio_item(smp_t dl, smp_t dr);
    refl_item_t it;
    it.mode  = MODE_AUDIO;
    it.dry_l = dl;
    it.dry_r = dr;
    it.chan  = 1'($urandom_range(0, 1));
    it.slot  = 4'($urandom_range(0, 15));
    it.dly   = TAP_DLY_W'($urandom);
    it.gain  = coef_t'($urandom);
    return it;
  endfunction

  function automatic refl_item_t tap_item(logic ch, logic [3:0] slot,
                                          logic [TAP_DLY_W-1:0] dly, coef_t gain);
    refl_item_t it;
    it.mode  = MODE_TAP;
    it.dry_l = smp_t'($urandom);
    it.dry_r = smp_t'($urandom);
    it.chan  = ch;
    it.slot  = slot;
    it.dly   = dly;
    it.gain  = gain;
    return it;
  endfunction

  function automatic smp_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return smp_t'(Q23_MAX);
      1:       return smp_t'(Q23_MIN);
      2, 3:    return smp_t'(int'($urandom_range(0, 2047)) - 1024);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // Mostly short delays so taps land on recent samples
  function automatic logic [TAP_DLY_W-1:0] rand_tap_delay();
    case ($urandom_range(0, 5))
      0:       return TAP_DLY_W'($urandom_range(1, 8));
      1, 2:    return TAP_DLY_W'($urandom_range(1, 64));
      3:       return TAP_DLY_W'($urandom_range(1, 700));
      4:       return TAP_DLY_W'($urandom);
      default: return '1;
    endcase
  endfunction

  function automatic coef_t rand_gain();
    case ($urandom_range(0, 5))
      0:       return coef_t'(-32768);
      1:       return coef_t'(32767);
      2, 3:    return coef_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic refl_item_t rand_tap_item();
    return tap_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                    rand_tap_delay(), rand_gain());
  endfunction

  function automatic logic [DLY_W-1:0] rand_dif_delay();
    case ($urandom_range(0, 4))
      0:       return DLY_W'(1);
      1:       return DLY_W'(511);
      default: return DLY_W'($urandom_range(1, 511));
    endcase
  endfunction

  function automatic coef_t rand_coeff();
    case ($urandom_range(0, 5))
      0:       return coef_t'(-32768);
      1:       return coef_t'(32767);
      2:       return '0;
      default: return coef_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until the transfer, then update the predictor
  task automatic send_item(refl_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 70);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid     <= 1'b1;
    mode         <= it.mode;
    sample_left  <= it.dry_l;
    sample_right <= it.dry_r;
    tap_channel  <= it.chan;
    tap_index    <= it.slot;
    tap_delay    <= it.dly;
    tap_gain     <= it.gain;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (it.mode == MODE_TAP) begin
      if (it.slot < TAP_COUNT) begin
        tap_dly_tab[it.chan][it.slot]  = it.dly;
        tap_gain_tab[it.chan][it.slot] = it.gain;
      end
    end else begin
      expected_pairs.push_back(predict_reflections(it.dry_l, it.dry_r));
    end
  endtask

  // Drop valid, wait for every result, then let the sequencer finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DLY_LA: dif_dly[0] = val[DLY_W-1:0];
      REG_DLY_LB: dif_dly[1] = val[DLY_W-1:0];
      REG_DLY_RA: dif_dly[2] = val[DLY_W-1:0];
      REG_DLY_RB: dif_dly[3] = val[DLY_W-1:0];
      REG_COEFF:  coeff_q    = coef_t'(val);
      REG_STEREO: stereo_on  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [DLY_W-1:0] la, logic [DLY_W-1:0] lb,
                               logic [DLY_W-1:0] ra, logic [DLY_W-1:0] rb,
                               coef_t coeff, logic stereo);
    write_reg(REG_DLY_LA, CFG_W'(la));
    write_reg(REG_DLY_LB, CFG_W'(lb));
    write_reg(REG_DLY_RA, CFG_W'(ra));
    write_reg(REG_DLY_RB, CFG_W'(rb));
    write_reg(REG_COEFF,  CFG_W'(coeff));
    write_reg(REG_STEREO, CFG_W'(stereo));
  endtask

  // Fill every slot of one table
  task automatic load_taps(logic ch);
    for (int t = 0; t < TAP_COUNT; t++)
      send_item(tap_item(ch, 4'(t), rand_tap_delay(), rand_gain()));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: check each transfer, then pick the next stall
  // ---------------------------------------------------------------------------

  task automatic check_pair();
    refl_pair_t want;
    if (expected_pairs.size() == 0) begin
      $error("unexpected result: out_left=%0d out_right=%0d", out_left, out_right);
      fail_count++;
    end else begin
      want = expected_pairs.pop_front();
      if (out_left !== want.out_l) begin
        $error("out_left expected %0d got %0d", want.out_l, out_left);
        fail_count++;
      end
      if (out_right !== want.out_r) begin
        $error("out_right expected %0d got %0d", want.out_r, out_right);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      check_pair();
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (style_left == 0) begin
        stall_style = flow_style_t'($urandom_range(0, 3));
        style_left  = $urandom_range(50, 400);
      end
      style_left--;
      case (stall_style)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= (cycle_count % 90) < 55;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset tables pass the dry signal; then load taps and drive extremes
  task automatic test_directed();
    send_item(audio_item('0, '0));
    send_item(audio_item(smp_t'(Q23_MAX), smp_t'(Q23_MIN)));
    send_item(audio_item(smp_t'(Q23_MIN), smp_t'(Q23_MAX)));
    send_item(audio_item(smp_t'(-1), smp_t'(1)));
    send_item(tap_item(1'b0, 4'd0,  14'd1,     coef_t'(32767)));
    send_item(tap_item(1'b0, 4'd15, 14'h3FFF,  coef_t'(-32768)));
    send_item(tap_item(1'b0, 4'd7,  14'd2,     coef_t'(-16384)));
    send_item(tap_item(1'b1, 4'd0,  14'd0,     coef_t'(16384)));
    send_item(tap_item(1'b1, 4'd3,  14'd1,     coef_t'(-32768)));
    send_item(tap_item(1'b1, 4'd10, 14'd5,     coef_t'(32767)));
    send_item(tap_item(1'b1, 4'd15, 14'h2AAA,  coef_t'(21845)));
    send_item(audio_item(smp_t'(Q23_MAX), smp_t'(Q23_MAX)));
    send_item(audio_item(smp_t'(Q23_MAX), smp_t'(Q23_MAX)));
    send_item(audio_item(smp_t'(Q23_MIN), smp_t'(Q23_MIN)));
    send_item(audio_item(smp_t'(Q23_MIN), smp_t'(Q23_MIN)));
    send_item(audio_item(smp_t'(1), smp_t'(-1)));
    send_item(audio_item(smp_t'(12345), smp_t'(-54321)));
    send_item(audio_item(smp_t'(24'h555555), smp_t'(24'hAAAAAA)));
    send_item(audio_item('0, '0));
    send_item(audio_item(smp_t'(Q23_MAX), smp_t'(Q23_MIN)));
    settle_block();
  endtask

  // Shortest and longest diffusers, coefficient extremes, mono and stereo
  task automatic test_register_extremes();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: apply_setting(9'd1, 9'd1, 9'd1, 9'd1, coef_t'(32767), 1'b1);
        1: apply_setting(9'd511, 9'd511, 9'd511, 9'd511, coef_t'(-32768), 1'b0);
        2: apply_setting(9'd1, 9'd511, 9'd511, 9'd1, '0, 1'b1);
        default: apply_setting(rand_dif_delay(), rand_dif_delay(), rand_dif_delay(),
                               rand_dif_delay(), coef_t'(-1), 1'b0);
      endcase
      load_taps(s[0]);
      for (int n = 0; n < 45; n++)
        send_item(audio_item(rand_sample(), rand_sample()));
      settle_block();
    end
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    apply_setting(rand_dif_delay(), rand_dif_delay(), rand_dif_delay(), rand_dif_delay(),
                  rand_coeff(), 1'b1);
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    for (int n = 0; n < 14; n++)
      send_item(audio_item(rand_sample(), rand_sample()));
    no_gaps = 1'b0;
    settle_block();
  endtask

  // Random settings per phase; mostly samples with table updates mixed in
  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      apply_setting(rand_dif_delay(), rand_dif_delay(), rand_dif_delay(), rand_dif_delay(),
                    rand_coeff(), ($urandom_range(0, 3) != 0));
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(0, 6) == 0)
          send_item(rand_tap_item());
        else
          send_item(audio_item(rand_sample(), rand_sample()));
      end
      settle_block();
    end
  endtask

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    settle_block();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
